>>> rtl/core/modbus_tcp_register_response_deframer_macros.svh
// ============================================================================
// Assertion macros for the Modbus TCP register response deframer
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ============================================================================
`ifndef MODBUS_TCP_REGISTER_RESPONSE_DEFRAMER_MACROS_SVH
`define MODBUS_TCP_REGISTER_RESPONSE_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define MTRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mtrd assertion failed");

// Next-cycle implication.
`define MTRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mtrd assertion failed");

`endif

>>> rtl/core/mtrd_pkg.sv
// ============================================================================
// mtrd_pkg
// Types, status codes and frame constants of the response deframer.
// ============================================================================
`default_nettype none

package mtrd_pkg;

    localparam int unsigned POS_W = 9;

    localparam logic [POS_W-1:0] POS_MAX    = 9'd511;
    localparam logic [POS_W-1:0] DATA_START = 9'd9;

    localparam logic [7:0] EXC_BIT   = 8'h80;
    localparam logic [7:0] FUNC_MASK = 8'h7F;
    localparam logic [7:0] FC_HOLD   = 8'd3;
    localparam logic [7:0] FC_INPUT  = 8'd4;

    typedef logic [3:0] status_t;

    localparam status_t ST_OK_REGS  = 4'd0;
    localparam status_t ST_OK_EXC   = 4'd1;
    localparam status_t ST_SHORT    = 4'd2;
    localparam status_t ST_PROTOCOL = 4'd3;
    localparam status_t ST_LENGTH   = 4'd4;
    localparam status_t ST_SIZE     = 4'd5;
    localparam status_t ST_FUNCTION = 4'd6;
    localparam status_t ST_ZERO     = 4'd7;
    localparam status_t ST_ODD      = 4'd8;
    localparam status_t ST_COUNT    = 4'd9;

    // Header fields as they stand after the current byte.
    typedef struct packed {
        logic [15:0]      proto;
        logic [15:0]      len;
        logic [7:0]       func;
        logic [7:0]       count;
        logic [POS_W-1:0] size;
    } hdr_t;

    // One result word.
    typedef struct packed {
        logic [6:0]  register_total;
        logic [7:0]  exc_code;
        logic [6:0]  func_code;
        logic [7:0]  unit_number;
        logic [15:0] transaction_value;
        status_t     status;
        logic [15:0] reg_value;
        logic        reg_valid;
        logic        frame_done;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mtrd_status.sv
// ============================================================================
// mtrd_status
// Priority-ordered frame status check from the header fields and frame size.
// ============================================================================
`default_nettype none

module mtrd_status (
    input  mtrd_pkg::hdr_t    hdr,
    output mtrd_pkg::status_t status
);
    import mtrd_pkg::*;

    logic [16:0] len_size;
    logic [9:0]  count_size;
    logic        is_exc;

    assign len_size   = {1'b0, hdr.len} + 17'd6;
    assign count_size = {2'b00, hdr.count} + 10'd9;
    assign is_exc     = (hdr.func & EXC_BIT) != 8'd0;

    always_comb begin
        if (hdr.size < 9'd9) begin
            status = ST_SHORT;
        end else if (is_exc) begin
            if (hdr.proto != 16'd0)       status = ST_PROTOCOL;
            else if (hdr.len != 16'd3)    status = ST_LENGTH;
            else if (hdr.size != 9'd9)    status = ST_SIZE;
            else                          status = ST_OK_EXC;
        end else if (hdr.proto != 16'd0) begin
            status = ST_PROTOCOL;
        end else if (hdr.len < 16'd3) begin
            status = ST_LENGTH;
        end else if ({8'd0, hdr.size} != len_size) begin
            status = ST_SIZE;
        end else if (hdr.func != FC_HOLD && hdr.func != FC_INPUT) begin
            status = ST_FUNCTION;
        end else if (hdr.count == 8'd0) begin
            status = ST_ZERO;
        end else if (hdr.count[0]) begin
            status = ST_ODD;
        end else if ({1'b0, hdr.size} != count_size) begin
            status = ST_COUNT;
        end else begin
            status = ST_OK_REGS;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/modbus_tcp_register_response_deframer.sv
// ============================================================================
// modbus_tcp_register_response_deframer
// Parses Modbus TCP read-registers responses byte by byte.
// ============================================================================
// Usage:
//   Slave channel carries one frame byte per word in s_tdata[7:0], with
//   s_tlast high on the final byte of the frame.
//   Master channel gives a word for each completed big-endian register
//   (m_tuser[0] = 1) and one word on the frame's last byte (m_tlast = 1)
//   that carries the status and header fields.
//   A result word is registered into the output buffer when the byte that
//   causes it is accepted.
//   Throughput: one byte per cycle while s_tready is high; the per-byte parse
//   and status check is one combinational pass into a two-word output buffer.
//   Stall: the output buffer holds two words; s_tready drops only while both
//   are full, so the sender keeps going while one result waits.
//   Reset (aresetn low, synchronous): byte counter, header stores and the
//   output buffer clear; the block is ready once reset is released.
//   Registers are emitted as they complete; the consumer drops them if the
//   final status is not ok.
// ============================================================================
`default_nettype none

module modbus_tcp_register_response_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] rx_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,     // frame_last
    // m_tdata: [15:0] reg_value, [19:16] status, [35:20] transaction_value,
    //          [43:36] unit_number, [50:44] func_code, [58:51] exc_code,
    //          [65:59] register_total, [71:66] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic             m_tlast,     // frame_done
    output logic [0:0]       m_tuser      // [0] reg_valid
);
    import mtrd_pkg::*;

    // Frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      trans_reg, trans_next;
    logic [15:0]      proto_reg, proto_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       unit_reg, unit_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       high_reg, high_next;

    // Two-word output buffer
    result_t    head_reg, tail_reg;
    logic [1:0] cnt_reg;

    logic       accept, push, pop;
    logic       reg_valid;
    logic [15:0] reg_value;
    hdr_t       hdr;
    status_t    status;
    logic       is_exc;
    result_t    res;

    assign s_tready = (cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    // Store the byte at its header slot, or pair it into a register.
    always_comb begin
        trans_next = trans_reg;
        proto_next = proto_reg;
        len_next   = len_reg;
        unit_next  = unit_reg;
        func_next  = func_reg;
        count_next = count_reg;
        high_next  = high_reg;
        reg_valid  = 1'b0;
        reg_value  = 16'd0;
        if (pos_reg < POS_MAX) begin
            case (pos_reg)
                9'd0: trans_next = {s_tdata, trans_reg[7:0]};
                9'd1: trans_next = {trans_reg[15:8], s_tdata};
                9'd2: proto_next = {s_tdata, proto_reg[7:0]};
                9'd3: proto_next = {proto_reg[15:8], s_tdata};
                9'd4: len_next   = {s_tdata, len_reg[7:0]};
                9'd5: len_next   = {len_reg[15:8], s_tdata};
                9'd6: unit_next  = s_tdata;
                9'd7: func_next  = s_tdata;
                9'd8: count_next = s_tdata;
                default: begin
                    // Data starts at an odd offset: odd = high byte, even = low.
                    if (pos_reg[0] == DATA_START[0]) begin
                        high_next = s_tdata;
                    end else begin
                        reg_valid = 1'b1;
                        reg_value = {high_reg, s_tdata};
                    end
                end
            endcase
        end
    end

    // Frame size counting the current byte, saturated.
    assign hdr.proto = proto_next;
    assign hdr.len   = len_next;
    assign hdr.func  = func_next;
    assign hdr.count = count_next;
    assign hdr.size  = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : POS_MAX;

    mtrd_status u_status (
        .hdr    (hdr),
        .status (status)
    );

    assign is_exc = (func_next & EXC_BIT) != 8'd0;

    always_comb begin
        res            = '0;
        res.reg_valid  = reg_valid;
        res.reg_value  = reg_value;
        if (s_tlast) begin
            res.frame_done        = 1'b1;
            res.status            = status;
            res.transaction_value = trans_next;
            res.unit_number       = unit_next;
            res.func_code         = 7'(func_next & FUNC_MASK);
            res.exc_code          = (status == ST_OK_EXC) ? count_next : 8'd0;
            res.register_total    = is_exc ? 7'd0 : count_next[7:1];
        end
    end

    assign push     = accept && (reg_valid || s_tlast);
    assign pos_next = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : POS_MAX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            trans_reg <= '0;
            proto_reg <= '0;
            len_reg   <= '0;
            unit_reg  <= '0;
            func_reg  <= '0;
            count_reg <= '0;
            high_reg  <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                // Frame closed: back to a clean header for the next one.
                pos_reg   <= '0;
                trans_reg <= '0;
                proto_reg <= '0;
                len_reg   <= '0;
                unit_reg  <= '0;
                func_reg  <= '0;
                count_reg <= '0;
                high_reg  <= '0;
            end else begin
                pos_reg   <= pos_next;
                trans_reg <= trans_next;
                proto_reg <= proto_next;
                len_reg   <= len_next;
                unit_reg  <= unit_next;
                func_reg  <= func_next;
                count_reg <= count_next;
                high_reg  <= high_next;
            end
        end
    end

    // Output buffer: head is what the master side shows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            if (push && !pop)      cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !push) begin
            head_reg <= tail_reg;
        end else if (push && !pop) begin
            if (cnt_reg == 2'd0) head_reg <= res;
            else                 tail_reg <= res;
        end else if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                head_reg <= res;
            end else begin
                head_reg <= tail_reg;
                tail_reg <= res;
            end
        end
    end

    assign m_tdata = {6'd0,
                      head_reg.register_total,
                      head_reg.exc_code,
                      head_reg.func_code,
                      head_reg.unit_number,
                      head_reg.transaction_value,
                      head_reg.status,
                      head_reg.reg_value};
    assign m_tlast    = head_reg.frame_done;
    assign m_tuser[0] = head_reg.reg_valid;

endmodule

`default_nettype wire

>>> rtl/core/mtrd_checker.sv
// ============================================================================
// mtrd_checker
// Port-level checks of the deframer's result channel, bound to the top level.
// ============================================================================
`default_nettype none

`include "modbus_tcp_register_response_deframer_macros.svh"

module mtrd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);
    import mtrd_pkg::*;

    // stalled word holds
    `MTRD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // no register means a zero value
    `MTRD_ASSERT_NOW(a_noreg_zero, m_tvalid && !m_tuser[0], m_tdata[15:0] == 16'd0)
    // mid-frame words are register words with empty frame fields
    `MTRD_ASSERT_NOW(a_mid, m_tvalid && !m_tlast, m_tuser[0] && m_tdata[65:16] == 50'd0)
    // exception code only with an ok exception status
    `MTRD_ASSERT_NOW(a_exc, m_tvalid && m_tlast && m_tdata[19:16] != ST_OK_EXC, m_tdata[58:51] == 8'd0)

endmodule

bind modbus_tcp_register_response_deframer mtrd_checker u_mtrd_checker (.*);

`default_nettype wire
